// ===== design/plid_pkg.sv =====
// Shared codes and field types for the positional list block.
// Used by the top level and by its port checker; depends on nothing.
package plid_pkg;

  // Field widths fixed by the interface.
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [VAL_W-1:0]    value_t;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Result status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== design/positional_list_insert_delete.sv =====
// A rejected request or an insert at the tail gives its result in the cycle after the transfer;
// an insert at p into n entries moves entries p..n up one place, then writes the value; a delete
// at p reads the removed entry, then moves the later entries down. One item is in work at a time,
// so throughput is set by the shift loop through the element memory: one entry moved per cycle.
// Reset (rst_n low, synchronous) empties the list and drops any result; memory keeps contents.
// Top level of the positional list; uses plid_pkg for codes and field types.
// The element store is a one-write, one-read memory with registered read data.
module positional_list_insert_delete #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic [plid_pkg::POS_W-1:0] in_position,
  input  logic signed [plid_pkg::VAL_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output plid_pkg::status_t        out_status,
  output logic signed [plid_pkg::VAL_W-1:0] out_removed_value,
  output logic [plid_pkg::LEN_W-1:0] out_list_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W) + 1;
  localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

  // Element memory and its registered read data.
  plid_pkg::value_t store_mem [CAPACITY];
  plid_pkg::value_t rd_data_r;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  plid_pkg::value_t mem_wd;
  logic             mem_re;
  logic [AW-1:0]    mem_ra;

  // Control and sequencing registers.
  logic             busy_r, busy_nxt;
  logic             cmd_r, cmd_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    stop_r, stop_nxt;
  logic             iss_r, iss_nxt;
  logic             wv_r, wv_nxt;
  logic             wfirst_r, wfirst_nxt;
  logic             first_r, first_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;
  plid_pkg::value_t val_r, val_nxt;
  plid_pkg::value_t rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // Result register.
  logic                             out_valid_r, out_valid_nxt;
  plid_pkg::status_t                out_status_r, out_status_nxt;
  plid_pkg::value_t                 out_removed_r, out_removed_nxt;
  logic [plid_pkg::LEN_W-1:0]       out_length_r, out_length_nxt;

  logic          acc;
  logic [EW-1:0] pos_e;
  logic [EW-1:0] cnt_e;
  logic          ins_bad;
  logic          del_bad;
  logic          is_full;

  // A new item is taken once the shifter is free and the result slot is free or emptying.
  assign in_stall = busy_r | (out_valid_r & out_stall);
  assign acc      = in_valid & ~in_stall;

  assign pos_e   = EW'(in_position);
  assign cnt_e   = EW'(cnt_r);
  assign ins_bad = (in_position == '0) || (pos_e > (cnt_e + EW'(1)));
  assign del_bad = (in_position == '0) || (pos_e > cnt_e);
  assign is_full = (cnt_e == CAP_E);

  // Next-state logic for the request check, the shift loop and the result slot.
  always_comb begin
    busy_nxt        = busy_r;
    cmd_nxt         = cmd_r;
    addr_nxt        = addr_r;
    stop_nxt        = stop_r;
    iss_nxt         = iss_r;
    wv_nxt          = 1'b0;
    wfirst_nxt      = 1'b0;
    first_nxt       = first_r;
    wa_nxt          = wa_r;
    val_nxt         = val_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_length_nxt  = out_length_r;
    mem_we          = 1'b0;
    mem_wa          = addr_r;
    mem_wd          = val_r;
    mem_re          = 1'b0;
    mem_ra          = addr_r;

    if (acc) begin
      if (in_command == plid_pkg::CMD_INSERT) begin
        if (ins_bad || is_full) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ins_bad ? plid_pkg::ST_RANGE : plid_pkg::ST_FULL;
          out_removed_nxt = '0;
          out_length_nxt  = plid_pkg::LEN_W'(cnt_r);
        end else if (pos_e == (cnt_e + EW'(1))) begin
          // Insert at the tail: nothing to move.
          mem_we          = 1'b1;
          mem_wa          = AW'(cnt_e);
          mem_wd          = in_value;
          cnt_nxt         = cnt_r + CW'(1);
          out_valid_nxt   = 1'b1;
          out_status_nxt  = plid_pkg::ST_OK;
          out_removed_nxt = '0;
          out_length_nxt  = plid_pkg::LEN_W'(cnt_r + CW'(1));
        end else begin
          // Move entries n-1 down to p-1 up by one place, then write the value.
          busy_nxt  = 1'b1;
          cmd_nxt   = plid_pkg::CMD_INSERT;
          addr_nxt  = AW'(cnt_e - EW'(1));
          stop_nxt  = AW'(pos_e - EW'(1));
          iss_nxt   = 1'b1;
          first_nxt = 1'b0;
          val_nxt   = in_value;
        end
      end else begin
        if (del_bad) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = plid_pkg::ST_RANGE;
          out_removed_nxt = '0;
          out_length_nxt  = plid_pkg::LEN_W'(cnt_r);
        end else begin
          // Read the removed entry, then move entries p to n-1 down by one place.
          busy_nxt  = 1'b1;
          cmd_nxt   = plid_pkg::CMD_DELETE;
          addr_nxt  = AW'(pos_e - EW'(1));
          stop_nxt  = AW'(cnt_e - EW'(1));
          iss_nxt   = 1'b1;
          first_nxt = 1'b1;
        end
      end
    end else if (busy_r) begin
      // Read side of the loop: one entry per cycle toward the stop address.
      if (iss_r) begin
        mem_re     = 1'b1;
        mem_ra     = addr_r;
        wv_nxt     = 1'b1;
        wfirst_nxt = first_r;
        first_nxt  = 1'b0;
        wa_nxt     = (cmd_r == plid_pkg::CMD_INSERT) ? addr_r + AW'(1) : addr_r - AW'(1);
        if (addr_r == stop_r) begin
          iss_nxt = 1'b0;
        end else begin
          addr_nxt = (cmd_r == plid_pkg::CMD_INSERT) ? addr_r - AW'(1) : addr_r + AW'(1);
        end
      end

      // Write side: the previous read lands one place over, or is a delete's removed entry.
      if (wv_r) begin
        if (wfirst_r) begin
          rem_nxt = rd_data_r;
        end else begin
          mem_we = 1'b1;
          mem_wa = wa_r;
          mem_wd = rd_data_r;
        end
      end

      // Loop drained: finish the operation and post the result.
      if (!iss_r && !wv_r) begin
        busy_nxt       = 1'b0;
        out_valid_nxt  = 1'b1;
        out_status_nxt = plid_pkg::ST_OK;
        if (cmd_r == plid_pkg::CMD_INSERT) begin
          mem_we          = 1'b1;
          mem_wa          = stop_r;
          mem_wd          = val_r;
          cnt_nxt         = cnt_r + CW'(1);
          out_removed_nxt = '0;
          out_length_nxt  = plid_pkg::LEN_W'(cnt_r + CW'(1));
        end else begin
          cnt_nxt         = cnt_r - CW'(1);
          out_removed_nxt = rem_r;
          out_length_nxt  = plid_pkg::LEN_W'(cnt_r - CW'(1));
        end
      end
    end
  end

  // Element memory: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[mem_ra];
    end
  end

  // Control state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      iss_r       <= 1'b0;
      wv_r        <= 1'b0;
      wfirst_r    <= 1'b0;
      first_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      iss_r       <= iss_nxt;
      wv_r        <= wv_nxt;
      wfirst_r    <= wfirst_nxt;
      first_r     <= first_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and address registers.
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    addr_r        <= addr_nxt;
    stop_r        <= stop_nxt;
    wa_r          <= wa_nxt;
    val_r         <= val_nxt;
    rem_r         <= rem_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_length_r  <= out_length_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_list_length   = out_length_r;

endmodule

// ===== design/plid_checker.sv =====
// Port-level checker for the positional list, bound to the top level.
// Depends on plid_pkg for status codes and field widths.
module plid_checker #(
  parameter int CAPACITY = 64
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input plid_pkg::status_t                  out_status,
  input logic [plid_pkg::VAL_W-1:0]         out_removed_value,
  input logic [plid_pkg::LEN_W-1:0]         out_list_length
);

  // A stalled result holds until its transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_removed_value) && $stable(out_list_length))
    else $error("stalled result changed");

  // A rejected request never reports a removed element.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != plid_pkg::ST_OK) |-> out_removed_value == '0)
    else $error("error result carries a removed value");

  // A full report only comes with a list at capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == plid_pkg::ST_FULL) |->
      out_list_length == plid_pkg::LEN_W'(CAPACITY))
    else $error("full status with list below capacity");

  // Reset drops any pending result.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind positional_list_insert_delete plid_checker #(.CAPACITY(CAPACITY)) u_plid_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_removed_value (out_removed_value),
  .out_list_length   (out_list_length)
);

// ===== sim/positional_list_insert_delete_tb.sv =====
// Testbench for the positional list block: directed and random insert/delete traffic
// checked against a scoreboard that keeps its own copy of the list contents.
// Depends on plid_pkg and the positional_list_insert_delete top level.
`timescale 1ns / 1ps

module positional_list_insert_delete_tb;

  localparam int DEPTH       = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [plid_pkg::POS_W-1:0] pos_t;
  typedef logic [plid_pkg::LEN_W-1:0] len_t;

  // One result item as the block should present it.
  typedef struct packed {
    plid_pkg::status_t status;
    plid_pkg::value_t  removed;
    len_t              length;
  } list_result_t;

  // Shadow copy of the list plus the queue of results still owed by the block.
  class list_scoreboard #(int CAP = 64);
    plid_pkg::value_t slots[CAP];
    int               fill;
    list_result_t     owed_q[$];
    int               errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // Apply one accepted request to the shadow list and queue its result.
    function void note_request(logic cmd, pos_t pos, plid_pkg::value_t val);
      list_result_t r;
      int k;
      r.status  = plid_pkg::ST_OK;
      r.removed = '0;
      if (cmd == plid_pkg::CMD_INSERT) begin
        if (pos < 1 || pos > fill + 1) begin
          r.status = plid_pkg::ST_RANGE;
        end else if (fill >= CAP) begin
          r.status = plid_pkg::ST_FULL;
        end else begin
          for (k = fill; k >= pos; k--) slots[k] = slots[k-1];
          slots[pos-1] = val;
          fill++;
        end
      end else begin
        if (pos < 1 || pos > fill) begin
          r.status = plid_pkg::ST_RANGE;
        end else begin
          r.removed = slots[pos-1];
          for (k = pos; k < fill; k++) slots[k-1] = slots[k];
          fill--;
        end
      end
      r.length = len_t'(fill);
      owed_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest owed one.
    task check_result(plid_pkg::status_t st, plid_pkg::value_t rm, len_t len);
      list_result_t e;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result with none owed: status=%0d removed=%h length=%0d",
                                  st, rm, len));
        return;
      end
      e = owed_q.pop_front();
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, owed %0d", st, e.status));
      if (rm !== e.removed)
        report_mismatch($sformatf("removed_value %h, owed %h", rm, e.removed));
      if (len !== e.length)
        report_mismatch($sformatf("list_length %0d, owed %0d", len, e.length));
    endtask
  endclass

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  logic   in_command;
  pos_t   in_position;
  logic signed [plid_pkg::VAL_W-1:0] in_value;
  logic   out_valid;
  logic   out_stall;
  plid_pkg::status_t out_status;
  logic signed [plid_pkg::VAL_W-1:0] out_removed_value;
  len_t   out_list_length;

  list_scoreboard #(DEPTH) board;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int gen_len;

  positional_list_insert_delete #(.CAPACITY(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_list_length   (out_list_length)
  );

  // Free-running clock and cycle count.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Receiver stalls at random on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watch both channels at the rising edge; a result never shares an edge with its own request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_result(out_status, out_removed_value, out_list_length);
      if (in_valid && !in_stall)
        board.note_request(in_command, in_position, in_value);
    end
  end

  // Timeout guard.
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("positional_list_insert_delete_tb: errors");
    $finish;
  end

  // Present one request, with random idle cycles first, and hold it until the transfer.
  task send_request(logic cmd, pos_t pos, plid_pkg::value_t val);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_value    <= val;
    // Track the length the stimulus side expects, to steer later positions.
    if (cmd == plid_pkg::CMD_INSERT) begin
      if (pos >= 1 && pos <= gen_len + 1 && gen_len < DEPTH) gen_len++;
    end else if (pos >= 1 && pos <= gen_len) begin
      gen_len--;
    end
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender off until every owed result has come back.
  task wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  function plid_pkg::value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic   cmd;
    pos_t   pos;
    int     hi;
    bit     filling;
    board         = new();
    gen_len       = 0;
    filling       = 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 82;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = plid_pkg::CMD_INSERT;
    in_position   = '0;
    in_value      = '0;
    out_stall     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list deletes, position zero, out-of-range positions, head/tail/middle.
    send_request(plid_pkg::CMD_DELETE, 7'd1,   32'h1234_5678);
    send_request(plid_pkg::CMD_DELETE, 7'd0,   32'h0);
    send_request(plid_pkg::CMD_INSERT, 7'd0,   32'h1);
    send_request(plid_pkg::CMD_INSERT, 7'd2,   32'h2);
    send_request(plid_pkg::CMD_INSERT, 7'd1,   32'h7FFF_FFFF);
    send_request(plid_pkg::CMD_INSERT, 7'd1,   32'h8000_0000);
    send_request(plid_pkg::CMD_INSERT, 7'd3,   32'hFFFF_FFFF);
    send_request(plid_pkg::CMD_INSERT, 7'd2,   32'h0);
    send_request(plid_pkg::CMD_INSERT, 7'd127, 32'h5555_5555);
    send_request(plid_pkg::CMD_INSERT, 7'd6,   32'hAAAA_AAAA);
    send_request(plid_pkg::CMD_DELETE, 7'd5,   32'h0);
    send_request(plid_pkg::CMD_DELETE, 7'd127, 32'hFFFF_FFFF);
    send_request(plid_pkg::CMD_DELETE, 7'd0,   32'h0);
    send_request(plid_pkg::CMD_DELETE, 7'd4,   32'h0);
    send_request(plid_pkg::CMD_DELETE, 7'd1,   32'h0);
    send_request(plid_pkg::CMD_INSERT, 7'd3,   32'hAAAA_AAAA);
    send_request(plid_pkg::CMD_INSERT, 7'd2,   32'h5555_5555);
    send_request(plid_pkg::CMD_DELETE, 7'd2,   32'hAAAA_AAAA);
    send_request(plid_pkg::CMD_DELETE, 7'd2,   32'h0);
    send_request(plid_pkg::CMD_DELETE, 7'd1,   32'h0);
    send_request(plid_pkg::CMD_DELETE, 7'd1,   32'h0);
    wait_for_drain();

    // Random: sweep the list between empty and full, with some malformed positions.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        wait_for_drain();
        send_idle_pct = 82;
        recv_idle_pct = 27;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        wait_for_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if ($urandom_range(0, 59) == 0) begin
        wait_for_drain();
      end

      if (gen_len == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (gen_len == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;

      if ($urandom_range(0, 99) < 85) begin
        cmd = filling ? plid_pkg::CMD_INSERT : plid_pkg::CMD_DELETE;
      end else begin
        cmd = filling ? plid_pkg::CMD_DELETE : plid_pkg::CMD_INSERT;
      end

      hi = (cmd == plid_pkg::CMD_INSERT) ? gen_len + 1 : gen_len;
      if ($urandom_range(0, 9) == 0 || hi < 1) begin
        pos = pos_t'($urandom_range(0, 127));
      end else begin
        case ($urandom_range(0, 3))
          0:       pos = 7'd1;
          1:       pos = pos_t'(hi);
          default: pos = pos_t'($urandom_range(1, hi));
        endcase
      end
      send_request(cmd, pos, pick_value());
    end

    // Let everything owed come back, then allow for one worst-case shift more.
    wait_for_drain();
    repeat (DEPTH + 8) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("positional_list_insert_delete_tb: clean");
    end else begin
      $display("positional_list_insert_delete_tb: errors");
    end
    $finish;
  end

endmodule
